@@ design/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Holds item structs, command and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_DEPTH     = 64;
    localparam int SPQ_KEY_WIDTH = 16;
    localparam int SPQ_ID_WIDTH  = 16;

    localparam int F_CMD_W    = 2;
    localparam int F_ID_W     = 16;
    localparam int F_KEY_W    = 16;
    localparam int F_CNT_W    = 7;
    localparam int F_STATUS_W = 2;

    typedef enum logic [F_CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_UPDATE = 2'd2
    } cmd_t;

    typedef enum logic [F_STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_EMPTY     = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RD,
        ST_DN_CMP,
        ST_FRONT_RD,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [F_CMD_W-1:0]        cmd;
        logic [F_ID_W-1:0]         item_id;
        logic signed [F_KEY_W-1:0] item_energy;
    } in_item_t;

    typedef struct packed {
        logic                         front_valid;
        logic [F_ID_W-1:0]            front_id;
        logic signed [F_KEY_W-1:0]    front_energy;
        logic [F_CNT_W-1:0]           entry_count;
        logic [F_STATUS_W-1:0]        status;
    } out_item_t;

endpackage

@@ design/spq_ram.sv @@
// ----------------------------------------------------------------------------
// spq_ram: entry store of the priority queue
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/spq_cmp.sv @@
// ----------------------------------------------------------------------------
// spq_cmp: shared entry comparator
// Orders two entries by signed key, then by id; also flags equal ids.
// ----------------------------------------------------------------------------
module spq_cmp #(
    parameter int KEY_WIDTH = 16,
    parameter int ID_WIDTH  = 16
) (
    input  logic [KEY_WIDTH-1:0] a_key,
    input  logic [ID_WIDTH-1:0]  a_id,
    input  logic [KEY_WIDTH-1:0] b_key,
    input  logic [ID_WIDTH-1:0]  b_id,
    output logic                 a_less,
    output logic                 id_eq
);

    logic key_lt;
    logic key_eq;

    assign key_lt = $signed(a_key) < $signed(b_key);
    assign key_eq = a_key == b_key;
    assign id_eq  = a_id == b_id;
    assign a_less = key_lt || (key_eq && (a_id < b_id));

endmodule

@@ design/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue: sorted-array priority queue with energy update
// Entries stay ordered in a store with one write and one read port; a sequencer
// shifts entries one slot per step through one shared comparator.
// ----------------------------------------------------------------------------
//  channel | ports                      | carries
//  --------+----------------------------+-------------------------------
//  input   | s_valid, s_ready, s_item   | cmd, item_id, item_energy
//  result  | m_valid, m_ready, m_item   | front, entry_count, status
//
// A remove or a rejected command goes straight to the front read and the result.
// An update first searches the entries for its id from slot 0 upward; an insert
// starts past the last entry and moves toward slot 0 past smaller entries, and a
// found update moves up past larger entries, then down past smaller ones. The
// store's single read port sets the pace, a read step and a compare step per slot.
// s_ready is high only while idle. Reset clears the count and control state;
// the store is not cleared. A stalled result holds in the output register; the
// next item is accepted and waits for it, adding the stall to its cycles.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH     = SPQ_DEPTH,
    parameter int KEY_WIDTH = SPQ_KEY_WIDTH,
    parameter int ID_WIDTH  = SPQ_ID_WIDTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENT_W = KEY_WIDTH + ID_WIDTH;

    state_t                state_reg,   state_next;
    logic [CNT_W-1:0]      idx_reg,     idx_next;
    logic [CNT_W-1:0]      count_reg,   count_next;
    logic [KEY_WIDTH-1:0]  new_key_reg, new_key_next;
    logic [ID_WIDTH-1:0]   new_id_reg,  new_id_next;
    status_t               status_reg,  status_next;
    out_item_t             out_reg,     out_next;
    logic                  m_valid_reg, m_valid_next;

    logic                  ram_wr_en;
    logic [IDX_W-1:0]      ram_wr_addr;
    logic [ENT_W-1:0]      ram_wr_data;
    logic                  ram_rd_en;
    logic [IDX_W-1:0]      ram_rd_addr;
    logic [ENT_W-1:0]      ram_rd_data;

    logic [KEY_WIDTH-1:0]  rd_key;
    logic [ID_WIDTH-1:0]   rd_id;
    logic [KEY_WIDTH-1:0]  cmp_a_key, cmp_b_key;
    logic [ID_WIDTH-1:0]   cmp_a_id,  cmp_b_id;
    logic                  cmp_less;
    logic                  cmp_id_eq;

    logic [CNT_W-1:0]      idx_inc, idx_dec, count_dec;
    logic [KEY_WIDTH+F_KEY_W-1:0] in_key_ext;
    logic [ID_WIDTH+F_ID_W-1:0]   in_id_ext;
    logic [KEY_WIDTH+F_KEY_W-1:0] rd_key_ext;
    logic [ID_WIDTH+F_ID_W-1:0]   rd_id_ext;
    logic [CNT_W+F_CNT_W-1:0]     cnt_ext;

    assign rd_key = ram_rd_data[ENT_W-1:ID_WIDTH];
    assign rd_id  = ram_rd_data[ID_WIDTH-1:0];

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign idx_dec   = idx_reg - CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);

    assign in_key_ext = {{KEY_WIDTH{s_item.item_energy[F_KEY_W-1]}}, s_item.item_energy};
    assign in_id_ext  = {{ID_WIDTH{1'b0}}, s_item.item_id};
    assign rd_key_ext = {{F_KEY_W{rd_key[KEY_WIDTH-1]}}, rd_key};
    assign rd_id_ext  = {{F_ID_W{1'b0}}, rd_id};
    assign cnt_ext    = {{F_CNT_W{1'b0}}, count_reg};

    // swap operands when the held entry moves toward the front
    always_comb begin
        if (state_reg == ST_UP_CMP) begin
            cmp_a_key = new_key_reg;
            cmp_a_id  = new_id_reg;
            cmp_b_key = rd_key;
            cmp_b_id  = rd_id;
        end else begin
            cmp_a_key = rd_key;
            cmp_a_id  = rd_id;
            cmp_b_key = new_key_reg;
            cmp_b_id  = new_id_reg;
        end
    end

    spq_cmp #(
        .KEY_WIDTH (KEY_WIDTH),
        .ID_WIDTH  (ID_WIDTH)
    ) u_cmp (
        .a_key  (cmp_a_key),
        .a_id   (cmp_a_id),
        .b_key  (cmp_b_key),
        .b_id   (cmp_b_id),
        .a_less (cmp_less),
        .id_eq  (cmp_id_eq)
    );

    spq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ENT_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        new_key_reg <= new_key_next;
        new_id_reg  <= new_id_next;
        status_reg  <= status_next;
        out_reg     <= out_next;
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        new_key_next = new_key_reg;
        new_id_next  = new_id_reg;
        status_next  = status_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = idx_reg[IDX_W-1:0];
        ram_wr_data  = {new_key_reg, new_id_reg};
        ram_rd_en    = 1'b0;
        ram_rd_addr  = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    new_key_next = in_key_ext[KEY_WIDTH-1:0];
                    new_id_next  = in_id_ext[ID_WIDTH-1:0];
                    status_next  = STATUS_OK;
                    state_next   = ST_FRONT_RD;
                    unique case (s_item.cmd)
                        CMD_INSERT: begin
                            if (count_reg == CNT_W'(DEPTH)) begin
                                status_next = STATUS_FULL;
                            end else begin
                                idx_next   = count_reg;
                                count_next = count_reg + CNT_W'(1);
                                state_next = ST_DN_RD;
                            end
                        end
                        CMD_REMOVE: begin
                            if (count_reg == '0) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                count_next = count_dec;
                            end
                        end
                        CMD_UPDATE: begin
                            if (count_reg == '0) begin
                                status_next = STATUS_NOT_FOUND;
                            end else begin
                                idx_next   = '0;
                                state_next = ST_FIND_RD;
                            end
                        end
                        default: begin
                            state_next = ST_FRONT_RD;
                        end
                    endcase
                end
            end
            ST_FIND_RD: begin
                ram_rd_en  = 1'b1;
                state_next = ST_FIND_CMP;
            end
            ST_FIND_CMP: begin
                if (cmp_id_eq) begin
                    state_next = ST_UP_RD;
                end else if (idx_inc == count_reg) begin
                    status_next = STATUS_NOT_FOUND;
                    state_next  = ST_FRONT_RD;
                end else begin
                    idx_next   = idx_inc;
                    state_next = ST_FIND_RD;
                end
            end
            ST_UP_RD: begin
                if (idx_inc != count_reg) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_inc[IDX_W-1:0];
                    state_next  = ST_UP_CMP;
                end else begin
                    state_next = ST_DN_RD;
                end
            end
            ST_UP_CMP: begin
                if (cmp_less) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_rd_data;
                    idx_next    = idx_inc;
                    state_next  = ST_UP_RD;
                end else begin
                    state_next = ST_DN_RD;
                end
            end
            ST_DN_RD: begin
                if (idx_reg == '0) begin
                    ram_wr_en  = 1'b1;
                    state_next = ST_FRONT_RD;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_dec[IDX_W-1:0];
                    state_next  = ST_DN_CMP;
                end
            end
            ST_DN_CMP: begin
                ram_wr_en = 1'b1;
                if (cmp_less) begin
                    ram_wr_data = ram_rd_data;
                    idx_next    = idx_dec;
                    state_next  = ST_DN_RD;
                end else begin
                    state_next = ST_FRONT_RD;
                end
            end
            ST_FRONT_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = count_dec[IDX_W-1:0];
                state_next  = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.front_valid  = count_reg != '0;
                    out_next.front_id     = (count_reg != '0) ? rd_id_ext[F_ID_W-1:0] : '0;
                    out_next.front_energy = (count_reg != '0) ? rd_key_ext[F_KEY_W-1:0] : '0;
                    out_next.entry_count  = cnt_ext[F_CNT_W-1:0];
                    out_next.status       = status_reg;
                    m_valid_next          = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

endmodule

@@ design/spq_checker.sv @@
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Watches both channels and the result fields over time.
// ----------------------------------------------------------------------------
module spq_checker
    import spq_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_item,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // hold the result while stalled
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // busy right after taking an item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accepted item");

    a_empty_front_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.front_valid |->
            m_item.front_id == '0 && m_item.front_energy == '0 && m_item.entry_count == '0)
        else $error("empty queue reports a front entry");

    a_status_front: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status == STATUS_FULL) |-> m_item.front_valid)
        else $error("full status with no front entry");

    a_status_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status == STATUS_EMPTY) |->
            !m_item.front_valid && m_item.entry_count == '0)
        else $error("empty status with entries held");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
